// ===== src/rro_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotation rows orthonormalizer package
// Shared fixed-point types, sizes and rounding/saturation helpers.
// ----------------------------------------------------------------------------
package rro_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int RND_W       = 64 - FRAC_BITS;
  localparam int SQ_W        = 64 - FRAC_BITS;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 31;
  localparam int NORM_STAGES = SQRT_STEPS + DIV_STEPS + 5;
  localparam int Q_DEPTH     = 4;
  localparam int QA_W        = $clog2(Q_DEPTH);

  localparam logic [31:0] DIV_INIT = 32'(64'd1 << (2 * FRAC_BITS - 31));

  typedef logic signed [31:0] fx_t;
  typedef logic signed [RND_W-1:0] rnd_t;

  localparam fx_t FX_MAX = 32'sh7fff_ffff;
  localparam fx_t FX_MIN = 32'sh8000_0000;

  typedef struct packed {
    fx_t x;
    fx_t y;
    fx_t z;
  } vec3_t;

  typedef struct packed {
    vec3_t side;
    vec3_t up;
    vec3_t fwd;
    logic  sat;
  } tok_t;

  typedef struct packed {
    vec3_t v;
    tok_t  t;
  } ctx_t;

  typedef struct packed {
    fx_t  v;
    logic s;
  } satr_t;

  function automatic logic signed [63:0] fmul(input fx_t a, input fx_t b);
    logic signed [63:0] p;
    p = a * b;
    return p;
  endfunction

  function automatic rnd_t rnd_shift(input logic signed [63:0] x);
    logic [63:0] half;
    logic [63:0] mag;
    rnd_t m;
    half = 64'd1 << (FRAC_BITS - 1);
    if (x[63]) begin
      mag = ($unsigned(-x) + half) >> FRAC_BITS;
    end else begin
      mag = ($unsigned(x) + half) >> FRAC_BITS;
    end
    m = $signed(mag[RND_W-1:0]);
    return x[63] ? -m : m;
  endfunction

  function automatic satr_t sat32(input logic signed [63:0] x);
    satr_t r;
    if (x > 64'sh0000_0000_7fff_ffff) begin
      r.v = FX_MAX;
      r.s = 1'b1;
    end else if (x < 64'shffff_ffff_8000_0000) begin
      r.v = FX_MIN;
      r.s = 1'b1;
    end else begin
      r.v = x[31:0];
      r.s = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== src/rotation_rows_orthonormalizer.sv =====
// ----------------------------------------------------------------------------
// Rotation rows orthonormalizer
// Re-orthonormalizes the side, up and forward rows of a pose rotation.
// ----------------------------------------------------------------------------
// Requests enter through a queue interface: a request is taken at a rising
// edge with push high and full low. Results leave the same way: the oldest
// result is on the out_ ports while empty is low and is taken at an edge
// with pop high. All values are signed Q4.28.
// A four-entry input queue feeds a 213-stage pipeline (three normalizers of
// 68 stages plus nine mixing stages), which feeds a four-entry result queue.
// Throughput is one request per cycle; each normalizer's digit-serial square
// root and reciprocal divide each occupy one pipeline stage per bit.
// While the result queue is full the whole pipeline holds; the input queue
// then takes up to four more requests before full rises.
// Reset empties both queues and clears all pipeline valid bits.
// ----------------------------------------------------------------------------
module rotation_rows_orthonormalizer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  rro_pkg::fx_t     in_side_x,
  input  rro_pkg::fx_t     in_side_y,
  input  rro_pkg::fx_t     in_side_z,
  input  rro_pkg::fx_t     in_up_x,
  input  rro_pkg::fx_t     in_up_y,
  input  rro_pkg::fx_t     in_up_z,
  input  rro_pkg::fx_t     in_fwd_x,
  input  rro_pkg::fx_t     in_fwd_y,
  input  rro_pkg::fx_t     in_fwd_z,
  output logic             empty,
  input  logic             pop,
  output rro_pkg::fx_t     out_new_side_x,
  output rro_pkg::fx_t     out_new_side_y,
  output rro_pkg::fx_t     out_new_side_z,
  output rro_pkg::fx_t     out_new_up_x,
  output rro_pkg::fx_t     out_new_up_y,
  output rro_pkg::fx_t     out_new_up_z,
  output rro_pkg::fx_t     out_new_fwd_x,
  output rro_pkg::fx_t     out_new_fwd_y,
  output rro_pkg::fx_t     out_new_fwd_z,
  output logic             out_saturated
);
  import rro_pkg::*;

  tok_t in_tok;
  tok_t iq_tok;
  logic iq_empty;
  logic oq_full;
  logic en;
  logic bk_vld;
  tok_t bk_tok;
  tok_t oq_tok;

  assign in_tok = '{side: '{in_side_x, in_side_y, in_side_z},
                    up:   '{in_up_x, in_up_y, in_up_z},
                    fwd:  '{in_fwd_x, in_fwd_y, in_fwd_z},
                    sat:  1'b0};

  assign en = !oq_full;

  rro_queue u_inq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (in_tok),
    .full  (full),
    .pop   (en),
    .rdata (iq_tok),
    .empty (iq_empty)
  );

  rro_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (!iq_empty),
    .in_tok  (iq_tok),
    .out_vld (bk_vld),
    .out_tok (bk_tok)
  );

  rro_queue u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bk_vld && en),
    .wdata (bk_tok),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_tok),
    .empty (empty)
  );

  assign out_new_side_x = oq_tok.side.x;
  assign out_new_side_y = oq_tok.side.y;
  assign out_new_side_z = oq_tok.side.z;
  assign out_new_up_x   = oq_tok.up.x;
  assign out_new_up_y   = oq_tok.up.y;
  assign out_new_up_z   = oq_tok.up.z;
  assign out_new_fwd_x  = oq_tok.fwd.x;
  assign out_new_fwd_y  = oq_tok.fwd.y;
  assign out_new_fwd_z  = oq_tok.fwd.z;
  assign out_saturated  = oq_tok.sat;

`ifndef SYNTHESIS
  a_out_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !(bk_vld && en)) |=> empty)
    else $error("result queue filled without a pipeline result");

  a_out_fill_source: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty) |-> $past(bk_vld && en))
    else $error("result appeared without a pipeline push");

  a_in_stays_full: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !(en && !iq_empty)) |=> full)
    else $error("input queue drained while the pipeline held");
`endif

endmodule

// ===== src/rro_queue.sv =====
// ----------------------------------------------------------------------------
// Request queue
// Small first-in first-out buffer of row sets with full and empty flags.
// ----------------------------------------------------------------------------
module rro_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rro_pkg::tok_t wdata,
  output logic          full,
  input  logic          pop,
  output rro_pkg::tok_t rdata,
  output logic          empty
);
  import rro_pkg::*;

  tok_t            mem_r [Q_DEPTH];
  logic [QA_W-1:0] wp_r;
  logic [QA_W-1:0] rp_r;
  logic [QA_W:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == (QA_W+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QA_W+1)'(do_push) - (QA_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== src/rro_norm.sv =====
// ----------------------------------------------------------------------------
// Vector normalizer
// Pipelined square, digit-serial square root, reciprocal divide and scale.
// ----------------------------------------------------------------------------
module rro_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  rro_pkg::vec3_t in_v,
  input  rro_pkg::tok_t  in_tok,
  output logic           out_vld,
  output rro_pkg::vec3_t out_v,
  output rro_pkg::tok_t  out_tok
);
  import rro_pkg::*;

  localparam int CTX_N = NORM_STAGES - 1;

  logic [NORM_STAGES-1:0] vld_r;
  ctx_t                   ctx_r [CTX_N];
  logic [SQ_W-1:0]        sq_r [3];
  logic [34:0]            rem_r [SQRT_STEPS];
  logic [31:0]            root_r [SQRT_STEPS+1];
  logic [63:0]            rad_r [SQRT_STEPS];
  logic [31:0]            dv_r [DIV_STEPS];
  logic [31:0]            den_r [DIV_STEPS];
  logic [DIV_STEPS-1:0]   q_r [DIV_STEPS+1];
  logic                   zf_r [DIV_STEPS+1];
  logic                   rs_r [DIV_STEPS+1];
  logic signed [63:0]     ml_r [3];
  logic                   mz_r;
  logic                   ms_r;
  logic [DIV_STEPS-1:0]   recip;
  satr_t                  os [3];
  vec3_t                  o_v_r;
  tok_t                   o_tok_r;
  tok_t                   o_tok_nxt;
  vec3_t                  o_v_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NORM_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= '{v: in_v, t: in_tok};
      for (int k = 1; k < CTX_N; k++) begin
        ctx_r[k] <= ctx_r[k-1];
      end
      sq_r[0] <= SQ_W'(rnd_shift(fmul(in_v.x, in_v.x)));
      sq_r[1] <= SQ_W'(rnd_shift(fmul(in_v.y, in_v.y)));
      sq_r[2] <= SQ_W'(rnd_shift(fmul(in_v.z, in_v.z)));
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      rad_r[0]  <= 64'(sq_r[0] + sq_r[1] + sq_r[2]) << FRAC_BITS;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [34:0] sh;
    logic [34:0] tr;
    logic        ge;
    assign sh = {rem_r[k][32:0], rad_r[k][63:62]};
    assign tr = {1'b0, root_r[k], 2'b01};
    assign ge = (sh >= tr);
    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k+1] <= {root_r[k][30:0], ge};
      end
    end
    if (k < SQRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? (sh - tr) : sh;
          rad_r[k+1] <= {rad_r[k][61:0], 2'b00};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0]  <= DIV_INIT;
      den_r[0] <= root_r[SQRT_STEPS];
      q_r[0]   <= '0;
      zf_r[0]  <= (root_r[SQRT_STEPS] == '0);
      rs_r[0]  <= (root_r[SQRT_STEPS] <= DIV_INIT);
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [32:0] t;
    logic [32:0] d;
    logic        ge;
    assign t  = {dv_r[k], 1'b0};
    assign d  = {1'b0, den_r[k]};
    assign ge = (t >= d);
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k+1]  <= {q_r[k][DIV_STEPS-2:0], ge};
        zf_r[k+1] <= zf_r[k];
        rs_r[k+1] <= rs_r[k];
      end
    end
    if (k < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv_r[k+1]  <= ge ? 32'(t - d) : t[31:0];
          den_r[k+1] <= den_r[k];
        end
      end
    end
  end

  assign recip = rs_r[DIV_STEPS] ? '1 : q_r[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      ml_r[0] <= fmul(ctx_r[CTX_N-2].v.x, $signed({1'b0, recip}));
      ml_r[1] <= fmul(ctx_r[CTX_N-2].v.y, $signed({1'b0, recip}));
      ml_r[2] <= fmul(ctx_r[CTX_N-2].v.z, $signed({1'b0, recip}));
      mz_r    <= zf_r[DIV_STEPS];
      ms_r    <= rs_r[DIV_STEPS];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      os[i] = sat32(64'(rnd_shift(ml_r[i])));
    end
    o_tok_nxt = ctx_r[CTX_N-1].t;
    o_tok_nxt.sat = ctx_r[CTX_N-1].t.sat
                    | (!mz_r && (ms_r || os[0].s || os[1].s || os[2].s));
    o_v_nxt.x = mz_r ? '0 : os[0].v;
    o_v_nxt.y = mz_r ? '0 : os[1].v;
    o_v_nxt.z = mz_r ? '0 : os[2].v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_v_r   <= o_v_nxt;
      o_tok_r <= o_tok_nxt;
    end
  end

  assign out_vld = vld_r[NORM_STAGES-1];
  assign out_v   = o_v_r;
  assign out_tok = o_tok_r;

endmodule

// ===== src/rro_back.sv =====
// ----------------------------------------------------------------------------
// Orthonormalization pipeline
// Normalizes up, removes its part from forward, normalizes forward, then
// rebuilds and normalizes side.
// ----------------------------------------------------------------------------
module rro_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  rro_pkg::tok_t in_tok,
  output logic          out_vld,
  output rro_pkg::tok_t out_tok
);
  import rro_pkg::*;

  logic               up_vld;
  vec3_t              up_v;
  tok_t               up_tok;
  tok_t               t1;
  logic [5:0]         mx_vld_r;
  tok_t               ma_tok_r;
  tok_t               mb_tok_r;
  tok_t               mc_tok_r;
  tok_t               md_tok_r;
  tok_t               me_tok_r;
  tok_t               mf_tok_r;
  tok_t               mc_tok_nxt;
  tok_t               me_tok_nxt;
  tok_t               mf_tok_nxt;
  logic signed [63:0] ma_r [3];
  rnd_t               mb_r [3];
  fx_t                mc_d_r;
  logic signed [63:0] md_r [3];
  fx_t                me_r [3];
  satr_t              ds;
  satr_t              ep [3];
  satr_t              fs [3];
  logic               fw_vld;
  vec3_t              fw_v;
  tok_t               fw_tok;
  tok_t               t2;
  logic [2:0]         cx_vld_r;
  tok_t               cg_tok_r;
  tok_t               ch_tok_r;
  tok_t               ci_tok_r;
  tok_t               ci_tok_nxt;
  logic signed [63:0] cg_r [6];
  rnd_t               ch_r [6];
  satr_t              cs [3];
  vec3_t              sd_v;
  tok_t               sd_tok;

  rro_norm u_up (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_vld),
    .in_v    (in_tok.up),
    .in_tok  (in_tok),
    .out_vld (up_vld),
    .out_v   (up_v),
    .out_tok (up_tok)
  );

  always_comb begin
    t1    = up_tok;
    t1.up = up_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mx_vld_r <= '0;
      cx_vld_r <= '0;
    end else if (en) begin
      mx_vld_r <= {mx_vld_r[4:0], up_vld};
      cx_vld_r <= {cx_vld_r[1:0], fw_vld};
    end
  end

  always_comb begin
    ds = sat32(64'(mb_r[0]) + 64'(mb_r[1]) + 64'(mb_r[2]));
    mc_tok_nxt     = mb_tok_r;
    mc_tok_nxt.sat = mb_tok_r.sat | ds.s;
    for (int i = 0; i < 3; i++) begin
      ep[i] = sat32(64'(rnd_shift(md_r[i])));
    end
    me_tok_nxt     = md_tok_r;
    me_tok_nxt.sat = md_tok_r.sat | ep[0].s | ep[1].s | ep[2].s;
    fs[0] = sat32(64'(me_tok_r.fwd.x) - 64'(me_r[0]));
    fs[1] = sat32(64'(me_tok_r.fwd.y) - 64'(me_r[1]));
    fs[2] = sat32(64'(me_tok_r.fwd.z) - 64'(me_r[2]));
    mf_tok_nxt       = me_tok_r;
    mf_tok_nxt.fwd.x = fs[0].v;
    mf_tok_nxt.fwd.y = fs[1].v;
    mf_tok_nxt.fwd.z = fs[2].v;
    mf_tok_nxt.sat   = me_tok_r.sat | fs[0].s | fs[1].s | fs[2].s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_tok_r <= t1;
      ma_r[0]  <= fmul(t1.fwd.x, t1.up.x);
      ma_r[1]  <= fmul(t1.fwd.y, t1.up.y);
      ma_r[2]  <= fmul(t1.fwd.z, t1.up.z);
      mb_tok_r <= ma_tok_r;
      for (int i = 0; i < 3; i++) begin
        mb_r[i] <= rnd_shift(ma_r[i]);
        me_r[i] <= ep[i].v;
      end
      mc_tok_r <= mc_tok_nxt;
      mc_d_r   <= ds.v;
      md_tok_r <= mc_tok_r;
      md_r[0]  <= fmul(mc_tok_r.up.x, mc_d_r);
      md_r[1]  <= fmul(mc_tok_r.up.y, mc_d_r);
      md_r[2]  <= fmul(mc_tok_r.up.z, mc_d_r);
      me_tok_r <= me_tok_nxt;
      mf_tok_r <= mf_tok_nxt;
    end
  end

  rro_norm u_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (mx_vld_r[5]),
    .in_v    (mf_tok_r.fwd),
    .in_tok  (mf_tok_r),
    .out_vld (fw_vld),
    .out_v   (fw_v),
    .out_tok (fw_tok)
  );

  always_comb begin
    t2     = fw_tok;
    t2.fwd = fw_v;
    for (int j = 0; j < 3; j++) begin
      cs[j] = sat32(64'(ch_r[2*j]) - 64'(ch_r[2*j+1]));
    end
    ci_tok_nxt        = ch_tok_r;
    ci_tok_nxt.side.x = cs[0].v;
    ci_tok_nxt.side.y = cs[1].v;
    ci_tok_nxt.side.z = cs[2].v;
    ci_tok_nxt.sat    = ch_tok_r.sat | cs[0].s | cs[1].s | cs[2].s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cg_tok_r <= t2;
      cg_r[0]  <= fmul(t2.up.y, t2.fwd.z);
      cg_r[1]  <= fmul(t2.up.z, t2.fwd.y);
      cg_r[2]  <= fmul(t2.up.z, t2.fwd.x);
      cg_r[3]  <= fmul(t2.up.x, t2.fwd.z);
      cg_r[4]  <= fmul(t2.up.x, t2.fwd.y);
      cg_r[5]  <= fmul(t2.up.y, t2.fwd.x);
      ch_tok_r <= cg_tok_r;
      for (int i = 0; i < 6; i++) begin
        ch_r[i] <= rnd_shift(cg_r[i]);
      end
      ci_tok_r <= ci_tok_nxt;
    end
  end

  rro_norm u_side (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (cx_vld_r[2]),
    .in_v    (ci_tok_r.side),
    .in_tok  (ci_tok_r),
    .out_vld (out_vld),
    .out_v   (sd_v),
    .out_tok (sd_tok)
  );

  always_comb begin
    out_tok      = sd_tok;
    out_tok.side = sd_v;
  end

endmodule

// ===== dv/rotation_rows_orthonormalizer_tb.sv =====
// ----------------------------------------------------------------------------
// Rotation rows orthonormalizer testbench
// Drives pose rotation requests through the input queue and compares every
// result with a fixed-point predictor of the up/forward/side rebuild. A
// directed table of extremes and degenerate rows comes first, then random
// near-unit rows mixed with raw random words, under three idling patterns.
// ----------------------------------------------------------------------------
module rotation_rows_orthonormalizer_tb;
  import rro_pkg::*;

  typedef struct {
    tok_t req;
    bit   typed;
    tok_t res;
  } row_t;

  localparam fx_t ONE = 32'sh1000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  tok_t req = '0;
  tok_t got;

  tok_t pending_res;
  tok_t rotations_due[$];
  row_t rows[$];
  int   send_idle = 8;
  int   recv_idle = 48;
  int   n_sent = 0;
  int   n_done = 0;
  int   n_sat = 0;
  int   errs = 0;

  always #2 clk = ~clk;

  rotation_rows_orthonormalizer dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_side_x(req.side.x), .in_side_y(req.side.y), .in_side_z(req.side.z),
    .in_up_x(req.up.x), .in_up_y(req.up.y), .in_up_z(req.up.z),
    .in_fwd_x(req.fwd.x), .in_fwd_y(req.fwd.y), .in_fwd_z(req.fwd.z),
    .empty(empty), .pop(pop),
    .out_new_side_x(got.side.x), .out_new_side_y(got.side.y),
    .out_new_side_z(got.side.z),
    .out_new_up_x(got.up.x), .out_new_up_y(got.up.y), .out_new_up_z(got.up.z),
    .out_new_fwd_x(got.fwd.x), .out_new_fwd_y(got.fwd.y),
    .out_new_fwd_z(got.fwd.z),
    .out_saturated(got.sat)
  );

  function automatic longint round_q(longint x);
    longint half;
    half = longint'(1) << (FRAC_BITS - 1);
    if (x >= 0) begin
      return (x + half) >>> FRAC_BITS;
    end
    return -((-x + half) >>> FRAC_BITS);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_q(a * b);
  endfunction

  function automatic longint clamp32(longint x, inout bit s);
    if (x > longint'(FX_MAX)) begin
      s = 1'b1;
      return longint'(FX_MAX);
    end
    if (x < longint'(FX_MIN)) begin
      s = 1'b1;
      return longint'(FX_MIN);
    end
    return x;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic void unitize(inout longint v[3], inout bit s);
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] inv;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += 64'(qmul(v[i], v[i]));
    len = floor_sqrt(sum << FRAC_BITS);
    if (len == 0) begin
      v = '{0, 0, 0};
      return;
    end
    inv = (64'd1 << (2 * FRAC_BITS)) / len;
    if (inv > 64'(FX_MAX)) begin
      s = 1'b1;
      inv = 64'(FX_MAX);
    end
    for (int i = 0; i < 3; i++) v[i] = clamp32(qmul(v[i], longint'(inv)), s);
  endfunction

  function automatic tok_t orthonormalize(tok_t t);
    longint u[3], f[3], sd[3];
    longint d, p;
    bit s;
    tok_t r;
    s = 1'b0;
    u = '{t.up.x, t.up.y, t.up.z};
    f = '{t.fwd.x, t.fwd.y, t.fwd.z};
    unitize(u, s);
    d = clamp32(qmul(f[0], u[0]) + qmul(f[1], u[1]) + qmul(f[2], u[2]), s);
    for (int i = 0; i < 3; i++) begin
      p = clamp32(qmul(u[i], d), s);
      f[i] = clamp32(f[i] - p, s);
    end
    unitize(f, s);
    sd[0] = clamp32(qmul(u[1], f[2]) - qmul(u[2], f[1]), s);
    sd[1] = clamp32(qmul(u[2], f[0]) - qmul(u[0], f[2]), s);
    sd[2] = clamp32(qmul(u[0], f[1]) - qmul(u[1], f[0]), s);
    unitize(sd, s);
    r.side = '{fx_t'(sd[0]), fx_t'(sd[1]), fx_t'(sd[2])};
    r.up = '{fx_t'(u[0]), fx_t'(u[1]), fx_t'(u[2])};
    r.fwd = '{fx_t'(f[0]), fx_t'(f[1]), fx_t'(f[2])};
    r.sat = s;
    return r;
  endfunction

  function automatic vec3_t v3(fx_t x, fx_t y, fx_t z);
    vec3_t v;
    v = '{x, y, z};
    return v;
  endfunction

  function automatic void add_row(vec3_t s, vec3_t u, vec3_t f, bit typed,
                                  tok_t res);
    row_t r;
    r.req = '{s, u, f, 1'b0};
    r.typed = typed;
    r.res = res;
    rows.push_back(r);
  endfunction

  function automatic fx_t near_unit();
    return fx_t'($urandom_range(0, 32'h2000_0000)) - ONE;
  endfunction

  function automatic fx_t raw_word();
    fx_t w;
    w = fx_t'($urandom);
    if ($urandom_range(0, 2) == 0) w = w >>> $urandom_range(0, 31);
    return w;
  endfunction

  task automatic compare(string name, fx_t e, fx_t a);
    if (e !== a) begin
      $error("%s expected %0d got %0d", name, e, a);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      rotations_due.push_back(pending_res);
      n_sent++;
    end
    if (rst_n && pop && !empty) begin
      if (rotations_due.size() == 0) begin
        $error("result with no request outstanding");
        errs++;
      end else begin
        tok_t e;
        e = rotations_due.pop_front();
        compare("new_side_x", e.side.x, got.side.x);
        compare("new_side_y", e.side.y, got.side.y);
        compare("new_side_z", e.side.z, got.side.z);
        compare("new_up_x", e.up.x, got.up.x);
        compare("new_up_y", e.up.y, got.up.y);
        compare("new_up_z", e.up.z, got.up.z);
        compare("new_fwd_x", e.fwd.x, got.fwd.x);
        compare("new_fwd_y", e.fwd.y, got.fwd.y);
        compare("new_fwd_z", e.fwd.z, got.fwd.z);
        compare("saturated", fx_t'(e.sat), fx_t'(got.sat));
        if (e.sat) n_sat++;
        n_done++;
      end
    end
  end

  always @(negedge clk) begin
    pop <= rst_n && ($urandom_range(0, 99) >= recv_idle);
  end

  initial begin
    #8_000_000;
    $display("FAIL rotation_rows_orthonormalizer");
    $finish;
  end

  initial begin
    tok_t zero_res, ident_res, r;
    int total;
    zero_res = '0;
    ident_res = '{v3(ONE, 0, 0), v3(0, ONE, 0), v3(0, 0, ONE), 1'b0};
    add_row(v3(0, 0, 0), v3(0, 0, 0), v3(0, 0, 0), 1'b1, zero_res);
    add_row(v3(ONE, 0, 0), v3(0, ONE, 0), v3(0, 0, ONE), 1'b1, ident_res);
    add_row(v3(FX_MAX, FX_MIN, -1), v3(0, ONE, 0), v3(0, 0, ONE), 1'b1, ident_res);
    add_row(v3(0, 0, 0), v3(1, 0, 0), v3(0, 0, ONE), 0, zero_res);
    add_row(v3(0, 0, 0), v3(32'sh4000, 0, 0), v3(0, ONE, 0), 0, zero_res);
    add_row(v3(0, 0, 0), v3(0, ONE, 0), v3(0, 32'sh2000_0000, 0), 0, zero_res);
    add_row(v3(0, 0, 0), v3(0, ONE, 0), v3(0, 0, 0), 0, zero_res);
    add_row(v3(0, 0, 0), v3(FX_MAX, FX_MAX, FX_MAX), v3(FX_MAX, FX_MAX, FX_MAX),
            0, zero_res);
    add_row(v3(0, 0, 0), v3(FX_MIN, FX_MIN, FX_MIN), v3(FX_MIN, FX_MIN, FX_MIN),
            0, zero_res);
    add_row(v3(-1, -1, -1), v3(FX_MAX, FX_MIN, FX_MAX), v3(FX_MIN, FX_MAX, 1),
            0, zero_res);
    add_row(v3(0, 0, 0), v3(-1, -1, -1), v3(FX_MAX, 0, FX_MIN), 0, zero_res);
    add_row(v3(0, 0, 0), v3(32'sh0800_0000, ONE, 0), v3(0, 32'sh0400_0000, ONE),
            0, zero_res);
    add_row(v3(0, 0, 0), v3(0, ONE, 0), v3(1, 0, 0), 0, zero_res);
    add_row(v3(0, 0, 0), v3(0, -ONE, 0), v3(-ONE, 0, 0), 0, zero_res);

    total = rows.size() + 1500;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < total; k++) begin
      if (k == total / 3) begin
        send_idle = 48;
        recv_idle = 8;
      end else if (k == 2 * total / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle) begin
        push <= 1'b0;
        @(negedge clk);
      end
      if (k < rows.size()) begin
        r = rows[k].req;
        pending_res = rows[k].typed ? rows[k].res : orthonormalize(r);
      end else begin
        r.side = v3(raw_word(), raw_word(), raw_word());
        if ($urandom_range(0, 3) != 0) begin
          r.up = v3(near_unit(), near_unit(), near_unit());
          r.fwd = v3(near_unit(), near_unit(), near_unit());
        end else begin
          r.up = v3(raw_word(), raw_word(), raw_word());
          r.fwd = v3(raw_word(), raw_word(), raw_word());
        end
        r.sat = 1'b0;
        pending_res = orthonormalize(r);
      end
      req <= r;
      push <= 1'b1;
      do @(posedge clk); while (full);
    end
    @(negedge clk);
    push <= 1'b0;
    wait (rotations_due.size() == 0);
    repeat (300) @(negedge clk);
    $display("Sent %0d rotations and checked %0d results, %0d of them saturated.",
             n_sent, n_done, n_sat);
    $display("Idling covered sender-heavy, receiver-heavy and back-to-back phases.");
    if (errs == 0 && rotations_due.size() == 0) begin
      $display("PASS rotation_rows_orthonormalizer");
    end else begin
      $display("FAIL rotation_rows_orthonormalizer");
    end
    $finish;
  end

endmodule

// ===== rotation_rows_orthonormalizer.f =====
src/rro_pkg.sv
src/rro_queue.sv
src/rro_norm.sv
src/rro_back.sv
src/rotation_rows_orthonormalizer.sv
dv/rotation_rows_orthonormalizer_tb.sv
